/* hdl/bce_pkg.sv */
// shared types, constants and curve lookup for the battery charge estimator
package bce_pkg;

    localparam logic [1:0] CFG_CELL_TYPE  = 2'd0;
    localparam logic [1:0] CFG_CELL_COUNT = 2'd1;
    localparam logic [1:0] CFG_SWAP_STEP  = 2'd2;

    localparam logic [19:0] MIN_CELL_V     = 20'd3000;
    localparam logic [13:0] FULL_PCT       = 14'd10000;
    localparam logic [7:0]  DEFAULT_CELLS  = 8'd6;
    localparam logic [39:0] ENERGY_MAX     = 40'hFF_FFFF_FFFF;

    localparam logic [4:0] DIV_STEPS_CELL   = 5'd20;
    localparam logic [4:0] DIV_STEPS_CURVE  = 5'd11;
    localparam logic [4:0] DIV_STEPS_ENERGY = 5'd14;

    localparam logic [14:0] CURVE_V [0:2][0:10] = '{
        '{15'd9000, 15'd10000, 15'd11000, 15'd11500, 15'd12000, 15'd12500,
          15'd13000, 15'd13500, 15'd14000, 15'd14500, 15'd15500},
        '{15'd10000, 15'd11000, 15'd11500, 15'd11800, 15'd12000, 15'd12200,
          15'd12400, 15'd12600, 15'd12800, 15'd13200, 15'd14000},
        '{15'd9000, 15'd12000, 15'd13000, 15'd13800, 15'd14200, 15'd14500,
          15'd14700, 15'd15000, 15'd15500, 15'd17000, 15'd17000}
    };
    localparam logic [13:0] CURVE_P [0:2][0:10] = '{
        '{14'd0, 14'd500, 14'd1500, 14'd2500, 14'd4000, 14'd5500,
          14'd7000, 14'd8000, 14'd8800, 14'd9400, 14'd10000},
        '{14'd0, 14'd500, 14'd1000, 14'd2000, 14'd3500, 14'd5000,
          14'd6500, 14'd8000, 14'd9000, 14'd9700, 14'd10000},
        '{14'd0, 14'd300, 14'd600, 14'd1200, 14'd2500, 14'd4500,
          14'd6500, 14'd8500, 14'd9500, 14'd10000, 14'd10000}
    };
    localparam logic [3:0]  CURVE_LEN  [0:2] = '{4'd11, 4'd11, 4'd10};
    localparam logic [14:0] CURVE_VMAX [0:2] = '{15'd15500, 15'd14000, 15'd17000};
    localparam logic [22:0] CELL_ENERGY [0:2] = '{23'd3000000, 23'd2900000, 23'd5000000};

    typedef enum logic [1:0] {
        DIV_CELL   = 2'd0,
        DIV_CURVE  = 2'd1,
        DIV_ENERGY = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic        latch;
        logic        acc;
        logic        start_div;
        div_sel_t    div_sel;
        logic        eval;
        logic        set_low;
        logic        mul1;
        logic        mul2;
        logic        keep_byv;
        logic        final_upd;
        logic        load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cell_low;
    } dp_sts_t;

    typedef struct packed {
        logic [13:0] base;
        logic [11:0] dv;
        logic [10:0] dp;
        logic [11:0] dd;
    } curve_seg_t;

    function automatic logic [1:0] chem_idx(input logic [1:0] c);
        chem_idx = (c == 2'd3) ? 2'd0 : c;
    endfunction

    // pick the curve segment; the ends give a fixed base with a zero slope term
    function automatic curve_seg_t curve_seg(input logic [1:0] c, input logic [19:0] v);
        curve_seg_t s;
        logic [1:0] ci;
        logic found;
        ci = chem_idx(c);
        s.base = 14'd0;
        s.dv = 12'd0;
        s.dp = 11'd0;
        s.dd = 12'd1;
        found = 1'b0;
        if (v <= {5'd0, CURVE_V[ci][0]}) begin
            s.base = 14'd0;
        end
        else if (v >= {5'd0, CURVE_VMAX[ci]}) begin
            s.base = FULL_PCT;
        end
        else begin
            for (int i = 1; i < 11; i++) begin
                if (!found && (4'(i) < CURVE_LEN[ci]) && (v < {5'd0, CURVE_V[ci][i]})) begin
                    found = 1'b1;
                    s.base = CURVE_P[ci][i-1];
                    s.dv = 12'(v - {5'd0, CURVE_V[ci][i-1]});
                    s.dp = 11'(CURVE_P[ci][i] - CURVE_P[ci][i-1]);
                    s.dd = 12'(CURVE_V[ci][i] - CURVE_V[ci][i-1]);
                end
            end
        end
        curve_seg = s;
    endfunction

endpackage

/* hdl/bce_div.sv */
// shared restoring divider, one quotient bit per cycle
module bce_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] hi,
    input  logic [19:0] lo,
    input  logic [4:0]  steps,
    input  logic [30:0] divisor,
    output logic        busy,
    output logic [19:0] quotient
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [19:0] lo_reg, lo_next;
    logic [19:0] quo_reg, quo_next;
    logic [30:0] d_reg, d_next;
    logic [31:0] trial;
    logic        ge;

    assign trial = {rem_reg, lo_reg[19]};
    assign ge = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        lo_next = lo_reg;
        quo_next = quo_reg;
        d_next = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = steps;
            rem_next = hi;
            lo_next = lo;
            quo_next = '0;
            d_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 31'(trial - {1'b0, d_reg}) : trial[30:0];
            lo_next = {lo_reg[18:0], 1'b0};
            quo_next = {quo_reg[18:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        quo_reg <= quo_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;
endmodule

/* hdl/bce_dp.sv */
// datapath: configuration, estimator state, arithmetic and result registers
module bce_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  bce_pkg::dp_cmd_t cmd,
    output bce_pkg::dp_sts_t sts,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [14:0]      cfg_data,
    input  logic [15:0]      pack_voltage_mv,
    input  logic [23:0]      energy_amount,
    output logic [13:0]      soc_centipercent,
    output logic             soc_known,
    output logic             swap_detected
);
    import bce_pkg::*;

    logic [1:0]  ctype_reg;
    logic [7:0]  ccount_reg;
    logic [14:0] sstep_reg;
    logic [39:0] used_reg, used_next;
    logic [19:0] last_reg;
    logic        last_valid_reg;
    logic [13:0] held_reg, held_next;
    logic        held_valid_reg;
    logic [15:0] pv_reg;
    logic [23:0] amt_reg;
    logic        fresh_reg;
    curve_seg_t  seg_reg;
    logic [30:0] cap_reg;
    logic [22:0] prod_reg;
    logic [30:0] diff_reg;
    logic [44:0] ne_reg;
    logic [13:0] byv_reg;
    logic [13:0] res_soc_reg;
    logic        res_known_reg;
    logic        res_swap_reg;
    logic [13:0] out_soc_reg;
    logic        out_known_reg;
    logic        out_swap_reg;

    logic [7:0]  cells;
    logic [19:0] pv10;
    logic [40:0] used_sum;
    logic [20:0] fresh_limit;
    logic        fresh;
    logic [13:0] now_soc;
    logic        div_start;
    logic [30:0] div_hi;
    logic [19:0] div_lo;
    logic [4:0]  div_steps;
    logic [30:0] div_d;
    logic        div_busy;
    logic [19:0] div_q;

    assign cells = (ccount_reg == 8'd0) ? DEFAULT_CELLS : ccount_reg;
    assign pv10 = {1'b0, pv_reg, 3'd0} + {3'd0, pv_reg, 1'b0};
    assign used_sum = {1'b0, used_reg} + {17'd0, amt_reg};
    assign fresh_limit = {1'b0, last_reg} + {6'd0, sstep_reg};
    assign fresh = last_valid_reg && ({1'b0, div_q} >= fresh_limit);
    assign now_soc = (byv_reg < div_q[13:0]) ? byv_reg : div_q[13:0];
    assign held_next = (!held_valid_reg || fresh_reg || now_soc < held_reg) ? now_soc : held_reg;

    always_comb
    begin
        used_next = used_reg;
        if (cmd.acc)
        begin
            used_next = used_sum[40] ? ENERGY_MAX : used_sum[39:0];
        end
        else if (cmd.eval && fresh)
        begin
            used_next = '0;
        end
    end

    always_comb
    begin
        div_start = cmd.start_div;
        unique case (cmd.div_sel)
            DIV_CELL:
            begin
                div_hi = '0;
                div_lo = pv10;
                div_steps = DIV_STEPS_CELL;
                div_d = {23'd0, cells};
            end
            DIV_CURVE:
            begin
                div_hi = {19'd0, prod_reg[22:11]};
                div_lo = {prod_reg[10:0], 9'd0};
                div_steps = DIV_STEPS_CURVE;
                div_d = {19'd0, seg_reg.dd};
            end
            DIV_ENERGY:
            begin
                div_hi = ne_reg[44:14];
                div_lo = {ne_reg[13:0], 6'd0};
                div_steps = DIV_STEPS_ENERGY;
                div_d = cap_reg;
            end
            default:
            begin
                div_hi = '0;
                div_lo = '0;
                div_steps = DIV_STEPS_CELL;
                div_d = 31'd1;
            end
        endcase
    end

    bce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .hi       (div_hi),
        .lo       (div_lo),
        .steps    (div_steps),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign sts.div_busy = div_busy;
    assign sts.cell_low = div_q <= MIN_CELL_V;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctype_reg <= 2'd0;
            ccount_reg <= DEFAULT_CELLS;
            sstep_reg <= 15'd1000;
            used_reg <= '0;
            last_reg <= '0;
            last_valid_reg <= 1'b0;
            held_reg <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CELL_TYPE:  ctype_reg <= cfg_data[1:0];
                    CFG_CELL_COUNT: ccount_reg <= cfg_data[7:0];
                    CFG_SWAP_STEP:  sstep_reg <= cfg_data;
                    default:        ;
                endcase
            end
            used_reg <= used_next;
            if (cmd.eval)
            begin
                last_reg <= div_q;
                last_valid_reg <= 1'b1;
            end
            if (cmd.final_upd)
            begin
                held_reg <= held_next;
                held_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pv_reg <= pack_voltage_mv;
            amt_reg <= energy_amount;
        end
        if (cmd.eval)
        begin
            fresh_reg <= fresh;
            seg_reg <= curve_seg(ctype_reg, div_q);
            cap_reg <= 31'(CELL_ENERGY[chem_idx(ctype_reg)] * cells);
        end
        if (cmd.mul1)
        begin
            prod_reg <= 23'(seg_reg.dv * seg_reg.dp);
            diff_reg <= ({9'd0, cap_reg} > used_reg) ? 31'({9'd0, cap_reg} - used_reg) : '0;
        end
        if (cmd.mul2)
        begin
            ne_reg <= 45'(diff_reg * FULL_PCT);
        end
        if (cmd.keep_byv)
        begin
            byv_reg <= 14'(seg_reg.base + div_q[13:0]);
        end
        if (cmd.set_low)
        begin
            res_soc_reg <= held_reg;
            res_known_reg <= held_valid_reg;
            res_swap_reg <= 1'b0;
        end
        if (cmd.final_upd)
        begin
            res_soc_reg <= held_next;
            res_known_reg <= 1'b1;
            res_swap_reg <= fresh_reg;
        end
        if (cmd.load_out)
        begin
            out_soc_reg <= res_soc_reg;
            out_known_reg <= res_known_reg;
            out_swap_reg <= res_swap_reg;
        end
    end

    assign soc_centipercent = out_soc_reg;
    assign soc_known = out_known_reg;
    assign swap_detected = out_swap_reg;
endmodule

/* hdl/bce_ctrl.sv */
// controller state machine sequencing the estimator datapath
module bce_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             kind,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output bce_pkg::dp_cmd_t cmd,
    input  bce_pkg::dp_sts_t sts
);
    import bce_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ENERGY = 12'b0000_0000_0010,
        S_DIVC   = 12'b0000_0000_0100,
        S_WC     = 12'b0000_0000_1000,
        S_CHECK  = 12'b0000_0001_0000,
        S_MUL1   = 12'b0000_0010_0000,
        S_MUL2   = 12'b0000_0100_0000,
        S_WV     = 12'b0000_1000_0000,
        S_ESTART = 12'b0001_0000_0000,
        S_WE     = 12'b0010_0000_0000,
        S_FINAL  = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall = state_reg != S_IDLE;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.div_sel = DIV_CELL;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    state_next = kind ? S_ENERGY : S_DIVC;
                end
            end
            S_ENERGY:
            begin
                cmd.acc = 1'b1;
                state_next = S_IDLE;
            end
            S_DIVC:
            begin
                cmd.start_div = 1'b1;
                state_next = S_WC;
            end
            S_WC:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.cell_low)
                begin
                    cmd.set_low = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.eval = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                cmd.start_div = 1'b1;
                cmd.div_sel = DIV_CURVE;
                state_next = S_WV;
            end
            S_WV:
            begin
                cmd.div_sel = DIV_CURVE;
                if (!sts.div_busy)
                begin
                    state_next = S_ESTART;
                end
            end
            S_ESTART:
            begin
                // curve quotient is still on the divider output this cycle
                cmd.keep_byv = 1'b1;
                cmd.start_div = 1'b1;
                cmd.div_sel = DIV_ENERGY;
                state_next = S_WE;
            end
            S_WE:
            begin
                cmd.div_sel = DIV_ENERGY;
                if (!sts.div_busy)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.final_upd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WE && !sts.div_busy) |=> state_reg == S_FINAL)
        else $error("energy division done but no final step");
`endif
endmodule

/* hdl/battery_charge_estimator_top.sv */
// Battery charge estimator: a voltage reading or an energy event per input transfer,
// and one result transfer per voltage reading.
// Input channel: in_valid/in_stall with kind, pack_voltage_mv and energy_amount.
// Output channel: out_valid/out_stall with soc_centipercent, soc_known, swap_detected.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high; writes are to be made while the block is idle, which the block does not enforce.
// One item is worked at a time. An energy event only adds to the energy counter. A reading at or
// below 0.3 V per cell needs only the per-cell division; other readings also run the curve
// and energy divisions on the shared one-bit-per-cycle divider.
// The finished result sits in an output register, so the next item is taken while the
// previous result still waits; a second result waits in the datapath result registers until the
// output register is free, and the input is stalled meanwhile.
// Reset clears the energy counter, the held estimate and its flags, and loads the
// register defaults (cell type 0, 6 cells, swap step 1000).
module battery_charge_estimator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] pack_voltage_mv,
    input  logic [23:0] energy_amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] soc_centipercent,
    output logic        soc_known,
    output logic        swap_detected,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import bce_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bce_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pack_voltage_mv  (pack_voltage_mv),
        .energy_amount    (energy_amount),
        .soc_centipercent (soc_centipercent),
        .soc_known        (soc_known),
        .swap_detected    (swap_detected)
    );
endmodule

/* tb/battery_charge_estimator_top_test.sv */
// testbench for the battery charge estimator: directed table plus random traffic
`timescale 1ns / 100ps

module battery_charge_estimator_top_test;
    import bce_pkg::*;

    localparam int NO_CHECK = -1;

    typedef enum logic { READING = 1'b0, SPENT = 1'b1 } item_kind_t;

    typedef struct {
        logic [13:0] soc;
        logic        known;
        logic        swap;
    } soc_result_t;

    typedef struct {
        item_kind_t  k;
        logic [15:0] mv;
        logic [23:0] uwh;
        int          want_soc;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] pack_voltage_mv;
    logic [23:0] energy_amount;
    logic        out_valid;
    logic        out_stall;
    logic [13:0] soc_centipercent;
    logic        soc_known;
    logic        swap_detected;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    battery_charge_estimator_top u_top (.*);

    // predictor state
    logic [1:0]  p_type;
    logic [7:0]  p_count;
    logic [14:0] p_step;
    logic [39:0] p_used;
    logic [19:0] p_last_v;
    logic        p_last_ok;
    logic [13:0] p_held;
    logic        p_held_ok;

    soc_result_t soc_expected[$];
    int          fixed_soc[$];
    int          errors;
    bit          out_rand;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #50ms;
        $display("battery_charge_estimator_top_test: done, errors");
        $finish;
    end

    function automatic logic [13:0] curve_pct(input logic [1:0] c, input logic [19:0] v);
        int vt [11];
        int pt [11];
        int n;
        int lo;
        unique case (c)
            2'd1:
            begin
                vt = '{10000, 11000, 11500, 11800, 12000, 12200, 12400, 12600, 12800,
                       13200, 14000};
                pt = '{0, 500, 1000, 2000, 3500, 5000, 6500, 8000, 9000, 9700, 10000};
                n = 11;
            end
            2'd2:
            begin
                vt = '{9000, 12000, 13000, 13800, 14200, 14500, 14700, 15000, 15500,
                       17000, 17000};
                pt = '{0, 300, 600, 1200, 2500, 4500, 6500, 8500, 9500, 10000, 10000};
                n = 10;
            end
            default:
            begin
                vt = '{9000, 10000, 11000, 11500, 12000, 12500, 13000, 13500, 14000,
                       14500, 15500};
                pt = '{0, 500, 1500, 2500, 4000, 5500, 7000, 8000, 8800, 9400, 10000};
                n = 11;
            end
        endcase
        if (v <= vt[0]) return 14'd0;
        if (v >= vt[n-1]) return 14'd10000;
        for (int i = 1; i < n; i++)
        begin
            if (v < vt[i])
            begin
                lo = pt[i-1] + ((int'(v) - vt[i-1]) * (pt[i] - pt[i-1])) / (vt[i] - vt[i-1]);
                return 14'(lo);
            end
        end
        return 14'd10000;
    endfunction

    function automatic void predict_charge(input item_kind_t k, input logic [15:0] mv,
                                           input logic [23:0] uwh);
        logic [7:0]  cells;
        logic [19:0] cv;
        logic [1:0]  c;
        logic [13:0] by_v;
        logic [13:0] by_e;
        logic [13:0] now_pct;
        logic [63:0] cap;
        logic        fresh;
        soc_result_t r;
        if (k == SPENT)
        begin
            p_used = (p_used > ENERGY_MAX - 40'(uwh)) ? ENERGY_MAX : p_used + 40'(uwh);
            return;
        end
        cells = (p_count == 8'd0) ? DEFAULT_CELLS : p_count;
        cv = 20'((32'(mv) * 10) / cells);
        if (cv <= MIN_CELL_V)
        begin
            r.soc = p_held_ok ? p_held : 14'd0;
            r.known = p_held_ok;
            r.swap = 1'b0;
            soc_expected.push_back(r);
            return;
        end
        fresh = p_last_ok && (21'(cv) >= 21'(p_last_v) + 21'(p_step));
        if (fresh) p_used = '0;
        p_last_v = cv;
        p_last_ok = 1'b1;
        c = (p_type == 2'd3) ? 2'd0 : p_type;
        by_v = curve_pct(c, cv);
        cap = (c == 2'd1) ? 64'd2900000 : (c == 2'd2) ? 64'd5000000 : 64'd3000000;
        cap = cap * cells;
        if (64'(p_used) >= cap) by_e = 14'd0;
        else by_e = 14'(((cap - 64'(p_used)) * 64'd10000) / cap);
        now_pct = (by_v < by_e) ? by_v : by_e;
        if (!p_held_ok || fresh || now_pct < p_held) p_held = now_pct;
        p_held_ok = 1'b1;
        r.soc = p_held;
        r.known = 1'b1;
        r.swap = fresh;
        soc_expected.push_back(r);
    endfunction

    // drops valid for the whole gap
    task automatic idle_gap(input bit allow);
        int n;
        if (!allow) return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        if (n == 0) return;
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_item(input item_kind_t k, input logic [15:0] mv,
                             input logic [23:0] uwh, input bit gaps, input int want);
        in_valid <= 1'b1;
        kind <= k;
        pack_voltage_mv <= mv;
        energy_amount <= uwh;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_charge(k, mv, uwh);
        if (k == READING) fixed_soc.push_back(want);
        @(negedge clk);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            idle_gap(1'b1);
        end
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (soc_expected.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        // energy events leave no result, so let the block settle
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        unique case (idx)
            CFG_CELL_TYPE:  p_type = val[1:0];
            CFG_CELL_COUNT: p_count = val[7:0];
            CFG_SWAP_STEP:  p_step = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        soc_result_t e;
        int w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (soc_expected.size() == 0)
            begin
                $error("unexpected result soc=%0d", soc_centipercent);
                errors++;
            end
            else
            begin
                e = soc_expected.pop_front();
                w = (fixed_soc.size() != 0) ? fixed_soc.pop_front() : NO_CHECK;
                if (soc_centipercent !== e.soc)
                begin
                    $error("soc_centipercent expected %0d got %0d", e.soc, soc_centipercent);
                    errors++;
                end
                if (w != NO_CHECK && int'(soc_centipercent) != w)
                begin
                    $error("soc_centipercent expected %0d got %0d", w, soc_centipercent);
                    errors++;
                end
                if (soc_known !== e.known)
                begin
                    $error("soc_known expected %0b got %0b", e.known, soc_known);
                    errors++;
                end
                if (swap_detected !== e.swap)
                begin
                    $error("swap_detected expected %0b got %0b", e.swap, swap_detected);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!out_rand) out_stall <= 1'b0;
        else if ($urandom_range(0, 39) == 0) out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t s;
        logic [15:0] v;
        errors = 0;
        out_rand = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        pack_voltage_mv = '0;
        energy_amount = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        p_type = 2'd0;
        p_count = 8'd6;
        p_step = 15'd1000;
        p_used = '0;
        p_last_v = '0;
        p_last_ok = 1'b0;
        p_held = '0;
        p_held_ok = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // low reading before any estimate, full pack, zero event, top of the curve
        rows = '{
            '{READING, 16'd0, 24'd0, 0},
            '{READING, 16'd1800, 24'd0, 0},
            '{SPENT, 16'd0, 24'd0, NO_CHECK},
            '{READING, 16'd9300, 24'd0, 10000},
            '{READING, 16'd8000, 24'd0, NO_CHECK},
            '{READING, 16'd1000, 24'd0, NO_CHECK},
            '{SPENT, 16'd0, 24'hFFFFFF, NO_CHECK},
            '{READING, 16'd7500, 24'd0, NO_CHECK},
            '{READING, 16'd9300, 24'd0, NO_CHECK},
            '{READING, 16'd5500, 24'd0, NO_CHECK},
            '{READING, 16'd65535, 24'd0, 10000},
            '{READING, 16'd5401, 24'd0, 0},
            '{READING, 16'd7000, 24'd0, NO_CHECK},
            '{READING, 16'hAAAA, 24'd0, NO_CHECK},
            '{SPENT, 16'hFFFF, 24'h555555, NO_CHECK},
            '{READING, 16'h5555, 24'hAAAAAA, NO_CHECK}
        };
        foreach (rows[i])
            send_item(rows[i].k, rows[i].mv, rows[i].uwh, 1'b0, rows[i].want_soc);
        in_valid <= 1'b0;
        drain_results();

        // large energy draw on a single cell with a zero swap step
        write_reg(CFG_CELL_COUNT, 15'd1);
        write_reg(CFG_SWAP_STEP, 15'd0);
        for (int i = 0; i < 4; i++) send_item(SPENT, 16'd0, 24'hFFFFFF, 1'b0, NO_CHECK);
        send_item(READING, 16'd1200, 24'd0, 1'b0, NO_CHECK);
        in_valid <= 1'b0;
        drain_results();

        out_rand = 1;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_CELL_TYPE, 15'd1); write_reg(CFG_CELL_COUNT, 15'd6); end
                1: begin write_reg(CFG_CELL_TYPE, 15'd2); write_reg(CFG_SWAP_STEP, 15'd20000); end
                2: begin write_reg(CFG_CELL_TYPE, 15'd3); write_reg(CFG_CELL_COUNT, 15'd0); end
                3: begin write_reg(CFG_CELL_COUNT, 15'd255); write_reg(CFG_SWAP_STEP, 15'h7FFF); end
                4: begin write_reg(CFG_CELL_TYPE, 15'd0); write_reg(CFG_CELL_COUNT, 15'd4); end
                5: begin write_reg(CFG_SWAP_STEP, 15'd500); write_reg(2'd3, 15'h7FFF); end
                6: begin write_reg(CFG_CELL_TYPE, 15'h7FFE); write_reg(CFG_CELL_COUNT, 15'h7F03); end
                default: begin write_reg(CFG_CELL_TYPE, 15'd1); write_reg(CFG_CELL_COUNT, 15'd12); end
            endcase
            for (int i = 0; i < 200; i++)
            begin
                s.want_soc = NO_CHECK;
                if ($urandom_range(0, 2) == 0)
                begin
                    s.k = SPENT;
                    s.mv = 16'($urandom);
                    s.uwh = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
                end
                else
                begin
                    s.k = READING;
                    s.uwh = 24'($urandom);
                    // mostly 250 to 1800 mV per cell for this pack, some anywhere
                    v = 16'((int'(p_count == 0 ? 6 : p_count) * $urandom_range(250, 1800)) / 1);
                    s.mv = ($urandom_range(0, 7) == 0) ? 16'($urandom) : v;
                end
                send_item(s.k, s.mv, s.uwh, 1'b1, NO_CHECK);
                idle_gap($urandom_range(0, 4) == 0);
                if (i == 100)
                begin
                    in_valid <= 1'b0;
                    drain_results();
                end
            end
            in_valid <= 1'b0;
            drain_results();
        end
        if (errors == 0)
            $display("battery_charge_estimator_top_test: done, clean");
        else
            $display("battery_charge_estimator_top_test: done, errors");
        $finish;
    end

endmodule

/* battery_charge_estimator_top.f */
hdl/bce_pkg.sv
hdl/bce_div.sv
hdl/bce_dp.sv
hdl/bce_ctrl.sv
hdl/battery_charge_estimator_top.sv
tb/battery_charge_estimator_top_test.sv
